@@ sv/wcpm_pkg.sv @@
// Shared types and constants for the weighted circular peak detector.
// Used by wcpm_front, wcpm_track and weighted_circular_peak_max.
package wcpm_pkg;

  // Frame length limit; the word at index MAX_BINS-1 always closes a frame.
  localparam int MAX_BINS = 4096;
  localparam int CNT_W    = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int THR_W    = 32;
  localparam int INDEX_W  = 12;

  // One bin after the multiply stage.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [PROD_W-1:0]   product;
    logic                last;
  } wcpm_bin_t;

  // Frame result handed from the tracker to the output register.
  typedef struct packed {
    logic                found;
    logic [INDEX_W-1:0]  index;
    logic [SAMPLE_W-1:0] value;
  } wcpm_result_t;

endpackage

@@ sv/weighted_circular_peak_max.sv @@
// Weighted circular spectral peak detector. Takes one bin word per cycle
// when not stalled (sample, Q1.15 weight, last) and after the closing word
// of a frame gives one result word: found, peak index and raw magnitude.
// The closing word passes from the input register to the multiply
// register, and the tracker then loads the output register from it.
// Words flow at one per cycle; the pipeline stalls only when a closing
// word meets a result word not yet taken. The user must write the
// threshold through cfg_we and cfg_wdata only while the block is idle;
// the block itself does not enforce this. A frame closes at the word
// marked last or at bin index MAX_BINS-1 (wcpm_pkg).
// Depends on wcpm_pkg, wcpm_front and wcpm_track.
module weighted_circular_peak_max (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wcpm_pkg::THR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wcpm_pkg::SAMPLE_W-1:0] sample,
  input  logic [wcpm_pkg::WEIGHT_W-1:0] weight,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [wcpm_pkg::INDEX_W-1:0]  peak_index,
  output logic [wcpm_pkg::SAMPLE_W-1:0] peak_value
);

  logic [wcpm_pkg::THR_W-1:0] threshold;
  logic                       bin_valid;
  wcpm_pkg::wcpm_bin_t        bin;
  logic                       take;
  logic                       emit;
  logic                       out_free;
  wcpm_pkg::wcpm_result_t     result;

  assign out_free = !out_valid || out_ready;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  wcpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .weight    (weight),
    .last      (last),
    .take      (take),
    .bin_valid (bin_valid),
    .bin       (bin)
  );

  wcpm_track u_track (
    .clk       (clk),
    .rst       (rst),
    .bin_valid (bin_valid),
    .bin       (bin),
    .threshold (threshold),
    .out_free  (out_free),
    .take      (take),
    .emit      (emit),
    .result    (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found      <= result.found;
      peak_index <= result.index;
      peak_value <= result.value;
    end
  end

endmodule

@@ sv/wcpm_front.sv @@
// Input register and multiply stage of the peak detector.
// Depends on wcpm_pkg for widths and the wcpm_bin_t word type.
module wcpm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wcpm_pkg::SAMPLE_W-1:0] sample,
  input  logic [wcpm_pkg::WEIGHT_W-1:0] weight,
  input  logic                          last,
  input  logic                          take,
  output logic                          bin_valid,
  output wcpm_pkg::wcpm_bin_t           bin
);

  logic                          i_valid;
  logic [wcpm_pkg::SAMPLE_W-1:0] i_sample;
  logic [wcpm_pkg::WEIGHT_W-1:0] i_weight;
  logic                          i_last;
  logic                          p_load;
  logic                          in_accept;
  logic [wcpm_pkg::PROD_W-1:0]   product;

  // Each stage moves when the one after it is empty or draining.
  assign p_load    = !bin_valid || take;
  assign in_ready  = !i_valid || p_load;
  assign in_accept = in_valid && in_ready;

  // Exact Q17.15 product, registered before any compare.
  assign product = wcpm_pkg::PROD_W'(i_sample) * wcpm_pkg::PROD_W'(i_weight);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid   <= 1'b0;
      bin_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        i_valid <= 1'b1;
      end else if (p_load) begin
        i_valid <= 1'b0;
      end
      if (p_load) begin
        bin_valid <= i_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      i_sample <= sample;
      i_weight <= weight;
      i_last   <= last;
    end
    if (p_load && i_valid) begin
      bin.sample  <= i_sample;
      bin.product <= product;
      bin.last    <= i_last;
    end
  end

endmodule

@@ sv/wcpm_track.sv @@
// Frame tracker: neighbor history, running best peak and close-of-frame pick.
// Depends on wcpm_pkg for widths, wcpm_bin_t and wcpm_result_t.
module wcpm_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bin_valid,
  input  wcpm_pkg::wcpm_bin_t           bin,
  input  logic [wcpm_pkg::THR_W-1:0]    threshold,
  input  logic                          out_free,
  output logic                          take,
  output logic                          emit,
  output wcpm_pkg::wcpm_result_t        result
);

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_FIRST,
    SRC_MID,
    SRC_BEST,
    SRC_LAST
  } src_t;

  // Frame state
  logic [wcpm_pkg::CNT_W-1:0]    bin_count;
  logic [wcpm_pkg::SAMPLE_W-1:0] first_sample;
  logic [wcpm_pkg::PROD_W-1:0]   first_product;
  logic [wcpm_pkg::SAMPLE_W-1:0] second_sample;
  logic [wcpm_pkg::SAMPLE_W-1:0] prev_sample;
  logic [wcpm_pkg::PROD_W-1:0]   prev_product;
  logic [wcpm_pkg::SAMPLE_W-1:0] before_prev_sample;
  logic                          best_valid;
  logic [wcpm_pkg::PROD_W-1:0]   best_product;
  logic [wcpm_pkg::CNT_W-1:0]    best_index;
  logic [wcpm_pkg::SAMPLE_W-1:0] best_sample;

  logic [wcpm_pkg::PROD_W-1:0]   thr;
  logic [wcpm_pkg::SAMPLE_W-1:0] s;
  logic [wcpm_pkg::PROD_W-1:0]   p;
  logic [wcpm_pkg::SAMPLE_W-1:0] second_eff;
  logic                          idx_ge1;
  logic                          idx_ge2;
  logic                          closing;
  logic                          gt_mb, gt_mt, gt_ft, gt_bf, gt_mf;
  logic                          gt_lt, gt_lf, gt_lb, gt_lm;
  logic                          mid_win;
  logic                          nb_valid;
  logic                          nb_gt_f;
  logic                          first_ok;
  logic                          use_nb;
  logic                          last_gt;
  logic                          last_ok;
  src_t                          src;

  assign thr = wcpm_pkg::PROD_W'(threshold);
  assign s   = bin.sample;
  assign p   = bin.product;

  assign idx_ge1 = (bin_count != '0);
  assign idx_ge2 = (bin_count > wcpm_pkg::CNT_W'(1));
  assign closing = bin.last || (bin_count == wcpm_pkg::CNT_W'(wcpm_pkg::MAX_BINS - 1));
  // In a two-bin frame bin 1 is the word now arriving.
  assign second_eff = (bin_count == wcpm_pkg::CNT_W'(1)) ? s : second_sample;

  // A closing word needs a free output register; other words always drain.
  assign take = bin_valid && (!closing || out_free);
  assign emit = take && closing;

  // All product compares in parallel; the selection below only muxes flags.
  assign gt_mb = prev_product  > best_product;
  assign gt_mt = prev_product  > thr;
  assign gt_ft = first_product > thr;
  assign gt_bf = best_product  > first_product;
  assign gt_mf = prev_product  > first_product;
  assign gt_lt = p > thr;
  assign gt_lf = p > first_product;
  assign gt_lb = p > best_product;
  assign gt_lm = p > prev_product;

  // Middle bin (index-1) is decided now that its right neighbor is here.
  assign mid_win = idx_ge2 && (prev_sample >= before_prev_sample) && (prev_sample >= s)
                   && (best_valid ? gt_mb : gt_mt);
  assign nb_valid = best_valid || mid_win;
  assign nb_gt_f  = mid_win ? gt_mf : gt_bf;

  // Bin 0 wraps to the last bin; earlier bins win ties.
  assign first_ok = (first_sample >= s) && (first_sample >= second_eff) && gt_ft;
  assign use_nb   = nb_valid && (!first_ok || nb_gt_f);
  always_comb begin
    if (use_nb) begin
      last_gt = mid_win ? gt_lm : gt_lb;
    end else if (first_ok) begin
      last_gt = gt_lf;
    end else begin
      last_gt = gt_lt;
    end
  end
  assign last_ok = (s >= prev_sample) && (s >= first_sample) && last_gt;

  // Winner of the closing frame
  always_comb begin
    priority if (!idx_ge1) begin
      src = SRC_NONE;
    end else if (last_ok) begin
      src = SRC_LAST;
    end else if (use_nb) begin
      src = mid_win ? SRC_MID : SRC_BEST;
    end else if (first_ok) begin
      src = SRC_FIRST;
    end else begin
      src = SRC_NONE;
    end
  end

  always_comb begin
    unique case (src)
      SRC_FIRST: begin
        result = '{found: 1'b1, index: '0, value: first_sample};
      end
      SRC_MID: begin
        result = '{found: 1'b1,
                   index: wcpm_pkg::INDEX_W'(bin_count - wcpm_pkg::CNT_W'(1)),
                   value: prev_sample};
      end
      SRC_BEST: begin
        result = '{found: 1'b1, index: wcpm_pkg::INDEX_W'(best_index), value: best_sample};
      end
      SRC_LAST: begin
        result = '{found: 1'b1, index: wcpm_pkg::INDEX_W'(bin_count), value: s};
      end
      default: begin
        result = '{found: 1'b0, index: '0, value: '0};
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count  <= '0;
      best_valid <= 1'b0;
    end else if (take) begin
      if (closing) begin
        bin_count  <= '0;
        best_valid <= 1'b0;
      end else begin
        bin_count  <= bin_count + wcpm_pkg::CNT_W'(1);
        best_valid <= nb_valid;
      end
    end
  end

  // History and best-peak payload
  always_ff @(posedge clk) begin
    if (take && !closing) begin
      if (!idx_ge1) begin
        first_sample  <= s;
        first_product <= p;
      end
      if (bin_count == wcpm_pkg::CNT_W'(1)) begin
        second_sample <= s;
      end
      if (mid_win) begin
        best_product <= prev_product;
        best_index   <= bin_count - wcpm_pkg::CNT_W'(1);
        best_sample  <= prev_sample;
      end
      before_prev_sample <= prev_sample;
      prev_sample        <= s;
      prev_product       <= p;
    end
  end

endmodule

@@ verif/weighted_circular_peak_max_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for weighted_circular_peak_max: directed and random frames,
// with a bit-exact peak predictor and a scoreboard on the result words.
// Depends on wcpm_pkg and the weighted_circular_peak_max RTL.
module weighted_circular_peak_max_test;
  import wcpm_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [THR_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample;
  logic [WEIGHT_W-1:0] weight;
  logic                last;
  logic                out_valid;
  logic                out_ready;
  logic                found;
  logic [INDEX_W-1:0]  peak_index;
  logic [SAMPLE_W-1:0] peak_value;

  weighted_circular_peak_max i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .weight     (weight),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .peak_index (peak_index),
    .peak_value (peak_value)
  );

  // Predictor state: threshold copy and the frame being scanned
  logic [THR_W-1:0]    thresh_model;
  logic [SAMPLE_W-1:0] first_mag;
  logic [PROD_W-1:0]   first_prod;
  logic [SAMPLE_W-1:0] second_mag;
  logic [SAMPLE_W-1:0] prev_mag;
  logic [PROD_W-1:0]   prev_prod;
  logic [SAMPLE_W-1:0] prev2_mag;
  int unsigned         frame_pos;
  logic [PROD_W-1:0]   best_prod;
  logic [INDEX_W-1:0]  best_idx;
  logic [SAMPLE_W-1:0] best_mag;
  logic                best_ok;

  wcpm_result_t expected_peaks[$];
  int unsigned  bins_taken;
  int unsigned  mismatch_count;
  int unsigned  stall_cycles;
  logic         no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_frame();
    first_mag  = '0;
    first_prod = '0;
    second_mag = '0;
    prev_mag   = '0;
    prev_prod  = '0;
    prev2_mag  = '0;
    frame_pos  = 0;
    best_prod  = '0;
    best_idx   = '0;
    best_mag   = '0;
    best_ok    = 1'b0;
  endfunction

  // Advance the peak search by one bin; queue a result when the frame closes
  function automatic void track_bin(input logic [SAMPLE_W-1:0] mag,
                                    input logic [WEIGHT_W-1:0] wgt, input logic lst);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] res_prod;
    int unsigned       idx;
    wcpm_result_t      res;
    prod = mag * wgt;
    idx  = frame_pos;
    if (idx == 0) begin
      first_mag  = mag;
      first_prod = prod;
    end
    if (idx == 1) second_mag = mag;

    // middle bin idx-1 is decided now that its right neighbor is known
    if (idx >= 2 && prev_mag >= prev2_mag && prev_mag >= mag) begin
      if (prev_prod > (best_ok ? best_prod : thresh_model)) begin
        best_ok   = 1'b1;
        best_prod = prev_prod;
        best_idx  = INDEX_W'(idx - 1);
        best_mag  = prev_mag;
      end
    end

    if (!lst && idx + 1 < MAX_BINS) begin
      prev2_mag = prev_mag;
      prev_mag  = mag;
      prev_prod = prod;
      frame_pos = idx + 1;
      return;
    end

    // frame closes: bin 0 first, then the middle winner, then the last bin
    res      = '0;
    res_prod = '0;
    if (idx >= 1) begin
      if (first_mag >= mag && first_mag >= second_mag && first_prod > thresh_model) begin
        res.found = 1'b1;
        res_prod  = first_prod;
        res.index = '0;
        res.value = first_mag;
      end
      if (best_ok && (!res.found || best_prod > res_prod)) begin
        res.found = 1'b1;
        res_prod  = best_prod;
        res.index = best_idx;
        res.value = best_mag;
      end
      if (mag >= prev_mag && mag >= first_mag &&
          prod > (res.found ? res_prod : thresh_model)) begin
        res.found = 1'b1;
        res_prod  = prod;
        res.index = INDEX_W'(idx);
        res.value = mag;
      end
    end
    expected_peaks.push_back(res);
    clear_frame();
  endfunction

  // Accept monitor and result scoreboard, both on pre-edge values
  always @(posedge clk) begin
    wcpm_result_t want;
    if (!rst && in_valid && in_ready) begin
      track_bin(sample, weight, last);
      bins_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_peaks.size() == 0) begin
        $error("result word with no frame pending: found %0d index %0d value %0d",
               found, peak_index, peak_value);
        mismatch_count++;
      end else begin
        want = expected_peaks.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          mismatch_count++;
        end
        if (peak_index !== want.index) begin
          $error("peak_index: expected %0d, got %0d", want.index, peak_index);
          mismatch_count++;
        end
        if (peak_value !== want.value) begin
          $error("peak_value: expected %0d, got %0d", want.value, peak_value);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side backpressure
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      out_ready = rst ? 1'b0 : (no_idle || $urandom_range(99) >= 28);
    end
  end

  // Present one bin word and hold it until taken; returns on a falling edge
  task automatic send_bin(input logic [SAMPLE_W-1:0] mag, input logic [WEIGHT_W-1:0] wgt,
                          input logic lst);
    int unsigned taken;
    if (!no_idle) begin
      while ($urandom_range(99) < 28) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    taken    = bins_taken;
    in_valid = 1'b1;
    sample   = mag;
    weight   = wgt;
    last     = lst;
    do @(negedge clk); while (bins_taken == taken);
  endtask

  // Drain all results, let the pipeline settle, then load a new threshold
  task automatic write_threshold(input logic [THR_W-1:0] value);
    in_valid = 1'b0;
    while (expected_peaks.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    thresh_model = value;
  endtask

  // One-bin and two-bin frames
  task automatic test_short_frames();
    write_threshold('0);
    send_bin(16'hFFFF, 16'hFFFF, 1'b1);
    send_bin(16'd5, 16'd100, 1'b0);
    send_bin(16'd5, 16'd100, 1'b1);
    send_bin(16'd3, 16'd100, 1'b0);
    send_bin(16'd9, 16'd100, 1'b1);
  endtask

  // Equal products: bin 0 wins over all, a middle bin wins over the last bin
  task automatic test_ties();
    send_bin(16'd7, 16'h8000, 1'b0);
    send_bin(16'd7, 16'h8000, 1'b0);
    send_bin(16'd7, 16'h8000, 1'b1);
    send_bin(16'd1, 16'h8000, 1'b0);
    send_bin(16'd7, 16'h8000, 1'b0);
    send_bin(16'd7, 16'h8000, 1'b1);
  endtask

  // Largest product against the threshold extremes, zero products, strict compare
  task automatic test_extremes();
    send_bin(16'd0, 16'hFFFF, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 1'b0);
    send_bin(16'd0, 16'hFFFF, 1'b1);
    send_bin(16'd0, 16'hFFFF, 1'b0);
    send_bin(16'hFFFF, 16'd0, 1'b1);
    write_threshold(32'hFFFF_FFFF);
    send_bin(16'd0, 16'hFFFF, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 1'b1);
    write_threshold(32'hFFFE_0000);
    send_bin(16'hFFFF, 16'hFFFF, 1'b0);
    send_bin(16'd0, 16'hFFFF, 1'b1);
    // product 3000 sits exactly on the threshold, then one above it
    write_threshold(32'd3000);
    send_bin(16'd0, 16'd1, 1'b0);
    send_bin(16'd1000, 16'd3, 1'b0);
    send_bin(16'd0, 16'd1, 1'b1);
    write_threshold(32'd2999);
    send_bin(16'd0, 16'd1, 1'b0);
    send_bin(16'd1000, 16'd3, 1'b0);
    send_bin(16'd0, 16'd1, 1'b1);
  endtask

  // Frame with no last mark: bin MAX_BINS-1 closes it, next word opens a new one
  task automatic test_overlong();
    write_threshold('0);
    for (int i = 0; i < MAX_BINS; i++) begin
      if (i == MAX_BINS - 1) send_bin(16'hFFFF, 16'hFFFF, 1'b0);
      else send_bin(SAMPLE_W'(i * 8), WEIGHT_W'($urandom), 1'b0);
    end
    send_bin(16'h00FF, 16'h0100, 1'b1);
  endtask

  // Random frames, mostly short, with content styles that provoke peaks and ties
  task automatic run_random_frames(input int unsigned item_budget);
    int unsigned sent;
    int unsigned len;
    int unsigned mag_style;
    int unsigned wgt_style;
    logic [SAMPLE_W-1:0] mag;
    logic [WEIGHT_W-1:0] wgt;
    sent = 0;
    while (sent < item_budget) begin
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = 2;
        8:       len = $urandom_range(25, 120);
        9:       len = $urandom_range(121, 400);
        default: len = $urandom_range(3, 24);
      endcase
      mag_style = $urandom_range(3);
      wgt_style = $urandom_range(3);
      for (int unsigned i = 0; i < len; i++) begin
        case (mag_style)
          0:       mag = SAMPLE_W'($urandom_range(3));
          1:       mag = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: mag = SAMPLE_W'($urandom);
        endcase
        case (wgt_style)
          0:       wgt = 16'h8000;
          1:       wgt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: wgt = WEIGHT_W'($urandom);
        endcase
        send_bin(mag, wgt, i == len - 1);
      end
      sent += len;
    end
  endtask

  // Random phases over several thresholds; one phase runs with no idling
  task automatic test_random();
    write_threshold('0);
    run_random_frames(400);
    write_threshold(THR_W'($urandom));
    run_random_frames(400);
    write_threshold(32'h1000_0000);
    no_idle = 1'b1;
    run_random_frames(400);
    no_idle = 1'b0;
    write_threshold(32'hFFFF_FFFF);
    run_random_frames(300);
    write_threshold(THR_W'($urandom_range(0, 32'h00FF_FFFF)));
    run_random_frames(500);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    sample         = '0;
    weight         = '0;
    last           = 1'b0;
    no_idle        = 1'b0;
    bins_taken     = 0;
    mismatch_count = 0;
    stall_cycles   = 0;
    thresh_model   = '0;
    clear_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_short_frames();
    test_ties();
    test_extremes();
    test_overlong();
    test_random();

    // drain and let the pipeline settle
    in_valid = 1'b0;
    while (expected_peaks.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
